/* hw/rtl/stream_substring_replace_defines.svh */
// assertion macros for the substring replace block
`ifndef STREAM_SUBSTRING_REPLACE_DEFINES_SVH
`define STREAM_SUBSTRING_REPLACE_DEFINES_SVH

// same-cycle implication, held off during reset
`define SSR_ASSERT_IMPLY(label, clk, rst, cond, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (cond) |-> (prop)) \
    else $error(msg);

// next-cycle implication, held off during reset
`define SSR_ASSERT_NEXT(label, clk, rst, cond, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (cond) |=> (prop)) \
    else $error(msg);

`endif

/* hw/rtl/ssr_pkg.sv */
// shared types and constants for the substring replace block
`timescale 1ns / 1ps
`default_nettype none
package ssr_pkg;

  localparam int MAX_PATTERN = 8;
  localparam int MAX_PASTE   = 8;
  localparam int RES_DEPTH   = (MAX_PATTERN > MAX_PASTE) ? MAX_PATTERN : MAX_PASTE;
  localparam int FILL_W      = $clog2(MAX_PATTERN);
  localparam int LEN_W       = 4;
  localparam int CNT_W       = $clog2(RES_DEPTH + 1);
  localparam int ADDR_W      = 5;
  localparam int DATA_W      = 64;

  localparam logic [1:0] REG_PATTERN_BYTES  = 2'd0;
  localparam logic [1:0] REG_PATTERN_LENGTH = 2'd1;
  localparam logic [1:0] REG_PASTE_BYTES    = 2'd2;
  localparam logic [1:0] REG_PASTE_LENGTH   = 2'd3;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       end_of_string;
  } ssr_in_t;

  typedef struct packed {
    logic [7:0] out_byte;
    logic       byte_valid;
    logic       last;
  } ssr_out_t;

  typedef struct packed {
    logic [8*MAX_PATTERN-1:0] pattern_bytes;
    logic [LEN_W-1:0]         plen;
    logic [8*MAX_PASTE-1:0]   paste_bytes;
    logic [LEN_W-1:0]         qlen;
  } ssr_cfg_t;

  typedef struct packed {
    ssr_out_t [RES_DEPTH-1:0] ent;
    logic [CNT_W-1:0]         count;
  } ssr_load_t;

endpackage
`default_nettype wire

/* hw/rtl/ssr_regs.sv */
// configuration register file with apb-style access
`timescale 1ns / 1ps
`default_nettype none
module ssr_regs (
  input  wire logic                       clk,
  input  wire logic                       rst,
  input  wire logic                       psel,
  input  wire logic                       penable,
  input  wire logic                       pwrite,
  input  wire logic [ssr_pkg::ADDR_W-1:0] paddr,
  input  wire logic [ssr_pkg::DATA_W-1:0] pwdata,
  output logic      [ssr_pkg::DATA_W-1:0] prdata,
  output logic                            pready,
  output ssr_pkg::ssr_cfg_t               cfg
);

  logic [8*ssr_pkg::MAX_PATTERN-1:0] pattern_bytes;
  logic [ssr_pkg::LEN_W-1:0]         pattern_length;
  logic [8*ssr_pkg::MAX_PASTE-1:0]   paste_bytes;
  logic [ssr_pkg::LEN_W-1:0]         paste_length;
  logic [1:0]                        reg_sel;
  logic                              wr_en;

  assign reg_sel = paddr[4:3];
  assign wr_en   = psel && penable && pwrite;
  assign pready  = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      pattern_bytes  <= '0;
      pattern_length <= '0;
      paste_bytes    <= '0;
      paste_length   <= '0;
    end else if (wr_en) begin
      case (reg_sel)
        ssr_pkg::REG_PATTERN_BYTES:  pattern_bytes  <= pwdata[8*ssr_pkg::MAX_PATTERN-1:0];
        ssr_pkg::REG_PATTERN_LENGTH: pattern_length <= pwdata[ssr_pkg::LEN_W-1:0];
        ssr_pkg::REG_PASTE_BYTES:    paste_bytes    <= pwdata[8*ssr_pkg::MAX_PASTE-1:0];
        ssr_pkg::REG_PASTE_LENGTH:   paste_length   <= pwdata[ssr_pkg::LEN_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    prdata = '0;
    case (reg_sel)
      ssr_pkg::REG_PATTERN_BYTES:  prdata = ssr_pkg::DATA_W'(pattern_bytes);
      ssr_pkg::REG_PATTERN_LENGTH: prdata = ssr_pkg::DATA_W'(pattern_length);
      ssr_pkg::REG_PASTE_BYTES:    prdata = ssr_pkg::DATA_W'(paste_bytes);
      ssr_pkg::REG_PASTE_LENGTH:   prdata = ssr_pkg::DATA_W'(paste_length);
      default:                     prdata = '0;
    endcase
  end

  // oversized lengths saturate
  always_comb begin
    cfg.pattern_bytes = pattern_bytes;
    cfg.paste_bytes   = paste_bytes;
    cfg.plen = (pattern_length > ssr_pkg::LEN_W'(ssr_pkg::MAX_PATTERN)) ?
               ssr_pkg::LEN_W'(ssr_pkg::MAX_PATTERN) : pattern_length;
    cfg.qlen = (paste_length > ssr_pkg::LEN_W'(ssr_pkg::MAX_PASTE)) ?
               ssr_pkg::LEN_W'(ssr_pkg::MAX_PASTE) : paste_length;
  end

endmodule
`default_nettype wire

/* hw/rtl/ssr_window.sv */
// pending-byte window, pattern compare and result list build
`timescale 1ns / 1ps
`default_nettype none
module ssr_window (
  input  wire logic                       clk,
  input  wire logic                       rst,
  input  wire ssr_pkg::ssr_cfg_t          cfg,
  input  wire logic                       step,
  input  wire ssr_pkg::ssr_in_t           item,
  output ssr_pkg::ssr_load_t              load,
  output logic      [ssr_pkg::FILL_W-1:0] fill
);

  logic [7:0]                 win      [ssr_pkg::MAX_PATTERN];
  logic [7:0]                 win_next [ssr_pkg::MAX_PATTERN];
  logic [7:0]                 ext      [ssr_pkg::MAX_PATTERN];
  logic [ssr_pkg::FILL_W-1:0] fill_next;
  logic [ssr_pkg::LEN_W-1:0]  fill_inc;
  logic                       at_len;
  logic                       hit;
  logic                       match;
  logic                       pop;
  logic                       eos;

  // window with the new byte written at the fill position
  always_comb begin
    for (int i = 0; i < ssr_pkg::MAX_PATTERN; i++) begin
      ext[i] = (ssr_pkg::FILL_W'(i) == fill) ? item.data_byte : win[i];
    end
  end

  always_comb begin
    eos      = item.end_of_string;
    fill_inc = ssr_pkg::LEN_W'(fill) + ssr_pkg::LEN_W'(1);
    at_len   = (fill_inc == cfg.plen);
    hit      = 1'b1;
    for (int i = 0; i < ssr_pkg::MAX_PATTERN; i++) begin
      if ((ssr_pkg::LEN_W'(i) < cfg.plen) && (ext[i] != cfg.pattern_bytes[8*i +: 8])) begin
        hit = 1'b0;
      end
    end
    match = at_len && hit;
    pop   = (fill_inc > cfg.plen) || (at_len && !hit);
  end

  // result list: replacement on a match, else window bytes from the oldest
  always_comb begin
    if (match) begin
      load.count = ssr_pkg::CNT_W'(cfg.qlen);
    end else if (eos) begin
      load.count = ssr_pkg::CNT_W'(fill_inc);
    end else if (pop) begin
      load.count = ssr_pkg::CNT_W'(1);
    end else begin
      load.count = '0;
    end
    for (int i = 0; i < ssr_pkg::RES_DEPTH; i++) begin
      load.ent[i].out_byte   = 8'h00;
      load.ent[i].byte_valid = 1'b1;
      if (match) begin
        if (i < ssr_pkg::MAX_PASTE) begin
          load.ent[i].out_byte = cfg.paste_bytes[8*i +: 8];
        end
      end else if (i < ssr_pkg::MAX_PATTERN) begin
        load.ent[i].out_byte = ext[i];
      end
    end
    // end of string with nothing left: bare end marker
    if (eos && (load.count == '0)) begin
      load.count             = ssr_pkg::CNT_W'(1);
      load.ent[0].out_byte   = 8'h00;
      load.ent[0].byte_valid = 1'b0;
    end
    for (int i = 0; i < ssr_pkg::RES_DEPTH; i++) begin
      load.ent[i].last = eos && (ssr_pkg::CNT_W'(i) == (load.count - ssr_pkg::CNT_W'(1)));
    end
  end

  always_comb begin
    for (int i = 0; i < ssr_pkg::MAX_PATTERN; i++) begin
      if (pop) begin
        win_next[i] = (i < ssr_pkg::MAX_PATTERN - 1) ? ext[(i + 1) % ssr_pkg::MAX_PATTERN]
                                                    : 8'h00;
      end else begin
        win_next[i] = ext[i];
      end
    end
    if (eos || match) begin
      fill_next = '0;
    end else if (pop) begin
      fill_next = fill;
    end else begin
      fill_next = fill_inc[ssr_pkg::FILL_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      fill <= '0;
      for (int i = 0; i < ssr_pkg::MAX_PATTERN; i++) begin
        win[i] <= 8'h00;
      end
    end else if (step) begin
      fill <= fill_next;
      for (int i = 0; i < ssr_pkg::MAX_PATTERN; i++) begin
        win[i] <= win_next[i];
      end
    end
  end

endmodule
`default_nettype wire

/* hw/rtl/ssr_emit.sv */
// result buffer, one beat per cycle from the head while out_ready is high
`timescale 1ns / 1ps
`default_nettype none
module ssr_emit (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               load_en,
  input  wire ssr_pkg::ssr_load_t load,
  input  wire logic               out_ready,
  output logic                    out_valid,
  output ssr_pkg::ssr_out_t       out_beat,
  output logic                    free,
  output logic [ssr_pkg::CNT_W-1:0] cnt
);

  ssr_pkg::ssr_out_t ent [ssr_pkg::RES_DEPTH];
  logic              take;

  assign out_valid = (cnt != '0);
  assign out_beat  = ent[0];
  assign take      = out_valid && out_ready;
  // empty now, or the last pending beat leaves this cycle
  assign free      = (cnt == '0) || ((cnt == ssr_pkg::CNT_W'(1)) && out_ready);

  always_ff @(posedge clk) begin
    if (rst) begin
      cnt <= '0;
    end else if (load_en) begin
      cnt <= load.count;
    end else if (take) begin
      cnt <= cnt - ssr_pkg::CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (load_en) begin
      for (int i = 0; i < ssr_pkg::RES_DEPTH; i++) begin
        ent[i] <= load.ent[i];
      end
    end else if (take) begin
      for (int i = 0; i < ssr_pkg::RES_DEPTH - 1; i++) begin
        ent[i] <= ent[i + 1];
      end
    end
  end

endmodule
`default_nettype wire

/* hw/rtl/stream_substring_replace.sv */
// top level of the streaming substring find-and-replace block
//
//   channel  | handshake                  | payload
//   ---------+----------------------------+---------------------------------
//   item     | item_valid / item_ready    | data_byte, end_of_string
//   result   | result_valid / result_ready| out_byte, byte_valid, last
//   config   | psel penable pwrite pready | paddr, pwdata, prdata (64 bit)
//
// one byte per cycle while each byte gives at most one beat and result_ready is
// high; a byte giving n beats (replacement or end-of-string flush) holds the
// result buffer until they leave; path: skid register, window logic, buffer
// reset clears the registers, the window and both stages; no clearing pass
// a stalled result side still lets one byte into the skid register
`timescale 1ns / 1ps
`default_nettype none
`include "stream_substring_replace_defines.svh"
module stream_substring_replace (
  input  wire logic                       clk,
  input  wire logic                       rst,
  input  wire logic                       item_valid,
  output logic                            item_ready,
  input  wire ssr_pkg::ssr_in_t           item,
  output logic                            result_valid,
  input  wire logic                       result_ready,
  output ssr_pkg::ssr_out_t               result,
  input  wire logic                       psel,
  input  wire logic                       penable,
  input  wire logic                       pwrite,
  input  wire logic [ssr_pkg::ADDR_W-1:0] paddr,
  input  wire logic [ssr_pkg::DATA_W-1:0] pwdata,
  output logic      [ssr_pkg::DATA_W-1:0] prdata,
  output logic                            pready
);

  ssr_pkg::ssr_cfg_t          cfg;
  ssr_pkg::ssr_in_t           s1;
  ssr_pkg::ssr_load_t         load;
  logic                       s1_valid;
  logic                       step;
  logic                       free;
  logic [ssr_pkg::FILL_W-1:0] win_fill;
  logic [ssr_pkg::CNT_W-1:0]  res_cnt;

  ssr_regs u_regs (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  // the byte in the skid register moves on once the result buffer drains
  assign step       = s1_valid && free;
  assign item_ready = !s1_valid || step;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (item_valid && item_ready) begin
      s1_valid <= 1'b1;
    end else if (step) begin
      s1_valid <= 1'b0;
    end
  end

  // skid payload, loaded with each accepted beat
  always_ff @(posedge clk) begin
    if (item_valid && item_ready) begin
      s1 <= item;
    end
  end

  ssr_window u_window (
    .clk  (clk),
    .rst  (rst),
    .cfg  (cfg),
    .step (step),
    .item (s1),
    .load (load),
    .fill (win_fill)
  );

  ssr_emit u_emit (
    .clk       (clk),
    .rst       (rst),
    .load_en   (step),
    .load      (load),
    .out_ready (result_ready),
    .out_valid (result_valid),
    .out_beat  (result),
    .free      (free),
    .cnt       (res_cnt)
  );

  // end of string always empties the window
  `SSR_ASSERT_NEXT(a_eos_flush, clk, rst, step && s1.end_of_string, win_fill == '0, "window not flushed at end of string")
  // end of string always yields at least one beat
  `SSR_ASSERT_IMPLY(a_eos_beat, clk, rst, step && s1.end_of_string, load.count != '0, "end of string gave no beat")
  // a bare marker only closes a string
  `SSR_ASSERT_IMPLY(a_bare_last, clk, rst, result_valid && !result.byte_valid, result.last && (res_cnt == ssr_pkg::CNT_W'(1)), "bare marker not final")

endmodule
`default_nettype wire

/* test/tb_stream_substring_replace.sv */
// self-checking testbench for the streaming substring find-and-replace block
`timescale 1ns / 1ps
module tb_stream_substring_replace;
  import ssr_pkg::*;

  // a byte that gives no beat may still be in flight when the last expected beat
  // arrives, so leave a margin before writes
  localparam int SETTLE_CYCLES = 8;
  // least number of random bytes sent in each random phase
  localparam int PHASE_BYTES = 45;

  logic clk = 1'b0;
  logic rst = 1'b1;

  // byte channel, sender side
  logic    item_valid = 1'b0;
  logic    item_ready;
  ssr_in_t item = '0;

  // beat channel, receiver side
  logic     result_valid;
  logic     result_ready = 1'b0;
  ssr_out_t result;

  // register port
  logic              psel = 1'b0;
  logic              penable = 1'b0;
  logic              pwrite = 1'b0;
  logic [ADDR_W-1:0] paddr = '0;
  logic [DATA_W-1:0] pwdata = '0;
  logic [DATA_W-1:0] prdata;
  logic              pready;

  // chance in a hundred that the sender idles or the receiver stalls in a cycle
  int idle_pct = 0;
  int stall_pct = 0;
  int error_count = 0;

  // our own copy of the registers and of the pending-byte window
  logic [63:0] pattern_copy = '0;
  logic [3:0]  pattern_len_copy = '0;
  logic [63:0] paste_copy = '0;
  logic [3:0]  paste_len_copy = '0;
  logic [7:0]  window_copy [8] = '{default: 8'h00};
  int unsigned window_level = 0;

  // beats still owed by the block, oldest first
  ssr_out_t expected_beats [$];

  stream_substring_replace dut (
    .clk          (clk),
    .rst          (rst),
    .item_valid   (item_valid),
    .item_ready   (item_ready),
    .item         (item),
    .result_valid (result_valid),
    .result_ready (result_ready),
    .result       (result),
    .psel         (psel),
    .penable      (penable),
    .pwrite       (pwrite),
    .paddr        (paddr),
    .pwdata       (pwdata),
    .prdata       (prdata),
    .pready       (pready)
  );

  initial begin
    forever #4 clk = ~clk;
  end

  // hard stop in case the block hangs
  initial begin
    #4_000_000;
    $display("TB_ERROR");
    $finish;
  end

  // receiver back-pressure, redrawn every cycle
  always @(posedge clk) begin
    result_ready <= ($urandom_range(99) >= stall_pct);
  end

  task automatic report_mismatch(input string msg);
    $display("mismatch: %s", msg);
    error_count++;
  endtask

  function automatic ssr_out_t data_beat(input logic [7:0] value);
    ssr_out_t b;
    b.out_byte = value;
    b.byte_valid = 1'b1;
    b.last = 1'b0;
    return b;
  endfunction

  // oldest pending byte leaves the window, zeros shift in at the top
  function automatic logic [7:0] pop_window();
    logic [7:0] oldest;
    oldest = window_copy[0];
    for (int i = 1; i < 8; i++) window_copy[i-1] = window_copy[i];
    window_copy[7] = 8'h00;
    if (window_level > 0) window_level--;
    return oldest;
  endfunction

  // works out the beats one accepted byte causes and queues them
  function automatic void predict_rewrite(input ssr_in_t byte_in);
    int unsigned plen;
    int unsigned qlen;
    bit          hit;
    ssr_out_t    produced [$];
    // oversized lengths saturate at the window and paste sizes
    plen = (pattern_len_copy > MAX_PATTERN) ? MAX_PATTERN : pattern_len_copy;
    qlen = (paste_len_copy > MAX_PASTE) ? MAX_PASTE : paste_len_copy;
    if (window_level > 7) window_level = 7;
    window_copy[window_level % 8] = byte_in.data_byte;
    window_level++;
    if (window_level > plen) begin
      // more pending than the pattern needs (shortened pattern or pass-through)
      produced.push_back(data_beat(pop_window()));
    end else if (window_level == plen) begin
      hit = 1'b1;
      for (int i = 0; i < plen; i++)
        if (window_copy[i] != pattern_copy[8*i +: 8]) hit = 1'b0;
      if (hit) begin
        for (int i = 0; i < qlen; i++) produced.push_back(data_beat(paste_copy[8*i +: 8]));
        window_copy = '{default: 8'h00};
        window_level = 0;
      end else begin
        // a failed compare only lets the oldest byte go, so partial matches survive
        produced.push_back(data_beat(pop_window()));
      end
    end
    if (byte_in.end_of_string) begin
      // flush what is left, in order
      while (window_level > 0 && produced.size() < 8) produced.push_back(data_beat(pop_window()));
      window_level = 0;
      if (produced.size() == 0) begin
        // deleted match at the very end: bare end marker
        produced.push_back('{out_byte: 8'h00, byte_valid: 1'b0, last: 1'b1});
      end else begin
        produced[produced.size()-1].last = 1'b1;
      end
    end
    foreach (produced[k]) expected_beats.push_back(produced[k]);
  endfunction

  // compare every accepted beat with the oldest expectation
  always @(posedge clk) begin
    ssr_out_t want;
    if (!rst && result_valid && result_ready) begin
      if (expected_beats.size() == 0) begin
        report_mismatch($sformatf("beat %h with nothing expected", result));
      end else begin
        want = expected_beats.pop_front();
        if (result.out_byte !== want.out_byte)
          report_mismatch($sformatf("out_byte %h, expected %h", result.out_byte, want.out_byte));
        if (result.byte_valid !== want.byte_valid)
          report_mismatch($sformatf("byte_valid %b, expected %b",
                                    result.byte_valid, want.byte_valid));
        if (result.last !== want.last)
          report_mismatch($sformatf("last %b, expected %b", result.last, want.last));
      end
    end
  end

  // one byte onto the channel; random idle cycles first, then hold until taken
  task automatic send_byte(input logic [7:0] value, input logic eos);
    ssr_in_t b;
    b.data_byte = value;
    b.end_of_string = eos;
    while ($urandom_range(99) < idle_pct) begin
      item_valid <= 1'b0;
      @(posedge clk);
    end
    item_valid <= 1'b1;
    item <= b;
    do @(posedge clk); while (!item_ready);
    predict_rewrite(b);
  endtask

  // sender stops until every owed beat has come, then lets the pipeline settle
  task automatic wait_idle();
    item_valid <= 1'b0;
    while (expected_beats.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // setup cycle, access cycle, written at the edge with penable and pready high
  task automatic write_register(input logic [1:0] index, input logic [63:0] value);
    @(posedge clk);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {index, 3'b000};
    pwdata <= value;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    case (index)
      REG_PATTERN_BYTES:  pattern_copy = value;
      REG_PATTERN_LENGTH: pattern_len_copy = value[3:0];
      REG_PASTE_BYTES:    paste_copy = value;
      REG_PASTE_LENGTH:   paste_len_copy = value[3:0];
      default: ;
    endcase
  endtask

  // empty pattern straight after reset: bytes pass unchanged, byte extremes
  task automatic test_passthrough();
    send_byte(8'h00, 1'b0);
    send_byte(8'hFF, 1'b1);
    wait_idle();
  endtask

  // "AB" -> "XYZ", with a partial match "AAB" whose first byte must survive
  task automatic test_replace_partial();
    write_register(REG_PATTERN_BYTES, 64'hFFFF_FFFF_FFFF_4241);
    write_register(REG_PATTERN_LENGTH, 64'd2);
    write_register(REG_PASTE_BYTES, 64'h0000_0000_005A_5958);
    write_register(REG_PASTE_LENGTH, 64'd3);
    send_byte(8'h41, 1'b0);
    send_byte(8'h41, 1'b0);
    send_byte(8'h42, 1'b0);
    send_byte(8'h43, 1'b0);
    send_byte(8'h41, 1'b0);
    send_byte(8'h42, 1'b1);
    wait_idle();
  endtask

  // empty replacement deletes; a deleted match on the last byte leaves a bare marker
  task automatic test_delete_at_end();
    write_register(REG_PASTE_LENGTH, 64'd0);
    send_byte(8'h43, 1'b0);
    send_byte(8'h41, 1'b0);
    send_byte(8'h42, 1'b1);
    wait_idle();
  endtask

  // lengths above the maximum saturate; junk above bit 3 is ignored; full 8-beat paste
  task automatic test_oversized_lengths();
    logic [63:0] pat;
    pat = 64'h00FF_00FF_8001_7F10;
    write_register(REG_PATTERN_BYTES, pat);
    write_register(REG_PATTERN_LENGTH, 64'hFFFF_FFFF_FFFF_FFFF);
    write_register(REG_PASTE_BYTES, 64'hFF00_1122_3344_5500);
    write_register(REG_PASTE_LENGTH, 64'h0000_0000_0000_000C);
    for (int k = 0; k < 8; k++) send_byte(pat[8*k +: 8], k == 7);
    wait_idle();
  endtask

  // window holds four bytes when the pattern drops to one byte: drains oldest first
  task automatic test_shorten_midstring();
    send_byte(8'h10, 1'b0);
    send_byte(8'h7F, 1'b0);
    send_byte(8'h01, 1'b0);
    send_byte(8'h80, 1'b0);
    wait_idle();
    write_register(REG_PATTERN_LENGTH, 64'hFFFF_FFFF_FFFF_FFF1);
    send_byte(8'h10, 1'b0);
    send_byte(8'hFF, 1'b1);
    wait_idle();
  endtask

  // random settings, strings built mostly from pattern pieces so that matches,
  // near misses and back-to-back occurrences are common
  task automatic test_random_phase(input int sender_idle, input int receiver_stall);
    logic [7:0]  alphabet [3];
    logic [7:0]  text [$];
    logic [63:0] pat;
    logic [63:0] len_word;
    logic [3:0]  plen_field;
    logic [3:0]  qlen_field;
    int unsigned plen_eff;
    int unsigned target;
    int unsigned part;
    int unsigned pick;
    int          sent_here;
    idle_pct = sender_idle;
    stall_pct = receiver_stall;
    sent_here = 0;
    while (sent_here < PHASE_BYTES) begin
      foreach (alphabet[k]) alphabet[k] = 8'($urandom_range(255));
      for (int k = 0; k < 8; k++) pat[8*k +: 8] = alphabet[$urandom_range(2)];
      pick = $urandom_range(99);
      plen_field = (pick < 5)  ? 4'd0 :
                   (pick < 12) ? 4'($urandom_range(9, 15)) :
                   (pick < 25) ? 4'd8 : 4'($urandom_range(1, 4));
      pick = $urandom_range(99);
      qlen_field = (pick < 15) ? 4'd0 :
                   (pick < 22) ? 4'($urandom_range(9, 15)) :
                   (pick < 32) ? 4'd8 : 4'($urandom_range(1, 5));
      plen_eff = (plen_field > 8) ? 8 : plen_field;
      // registers only change with nothing owed and the pipeline quiet
      wait_idle();
      write_register(REG_PATTERN_BYTES, pat);
      len_word = ($urandom_range(3) == 0) ? {$urandom, $urandom} : 64'd0;
      len_word[3:0] = plen_field;
      write_register(REG_PATTERN_LENGTH, len_word);
      write_register(REG_PASTE_BYTES, {$urandom, $urandom});
      len_word = ($urandom_range(3) == 0) ? {$urandom, $urandom} : 64'd0;
      len_word[3:0] = qlen_field;
      write_register(REG_PASTE_LENGTH, len_word);
      repeat ($urandom_range(2, 5)) begin
        text.delete();
        target = $urandom_range(1, 12);
        while (text.size() < target) begin
          pick = $urandom_range(99);
          if (pick < 35) begin
            for (int k = 0; k < plen_eff; k++) text.push_back(pat[8*k +: 8]);
          end else if (pick < 55) begin
            // broken occurrence: a prefix of the pattern
            part = $urandom_range(plen_eff);
            for (int k = 0; k < part; k++) text.push_back(pat[8*k +: 8]);
          end else if (pick < 85) begin
            text.push_back(alphabet[$urandom_range(2)]);
          end else begin
            text.push_back(8'($urandom_range(255)));
          end
        end
        foreach (text[k]) send_byte(text[k], k == text.size() - 1);
        sent_here += text.size();
      end
    end
    wait_idle();
  endtask

  initial begin
    repeat (4) @(posedge clk);
    rst <= 1'b0;
    test_passthrough();
    test_replace_partial();
    test_delete_at_end();
    test_oversized_lengths();
    test_shorten_midstring();
    // no idling, sender idling, receiver stalling, both
    test_random_phase(0, 0);
    test_random_phase(85, 0);
    test_random_phase(0, 85);
    test_random_phase(28, 28);
    wait_idle();
    if (error_count == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule

/* sim.f */
+incdir+hw/rtl
hw/rtl/ssr_pkg.sv
hw/rtl/ssr_regs.sv
hw/rtl/ssr_window.sv
hw/rtl/ssr_emit.sv
hw/rtl/stream_substring_replace.sv
test/tb_stream_substring_replace.sv
